// ===== design/vgsl_pkg.sv =====
// vgsl_pkg: types and constants shared by the vertical glyph substitution lookup
// no dependencies; used by vgsl_ram, vertical_glyph_substitution_lookup, vgsl_checker and the test
package vgsl_pkg;

    localparam int TABLE_WORDS_DEF = 4096;
    localparam int PTR_W           = 19;

    localparam logic [15:0] END_MARK  = 16'd255;
    localparam logic [15:0] COV_LIST  = 16'd1;
    localparam logic [15:0] COV_RANGE = 16'd2;
    localparam logic [15:0] SUB_DELTA = 16'd1;

    localparam logic KIND_WRITE  = 1'b0;
    localparam logic KIND_LOOKUP = 1'b1;

    typedef struct packed {
        logic        kind;
        logic [11:0] word_address;
        logic [15:0] word_data;
        logic [15:0] glyph;
    } req_t;

    typedef struct packed {
        logic [15:0] result_glyph;
        logic        substituted;
        logic        table_error;
    } rsp_t;

endpackage

// ===== design/vgsl_ram.sv =====
// vgsl_ram: generic single-write, single-read ram with registered read data
// depends on vgsl_pkg for the default depth
module vgsl_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = vgsl_pkg::TABLE_WORDS_DEF
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== design/vertical_glyph_substitution_lookup.sv =====
// vertical_glyph_substitution_lookup: table store plus sequencer that walks the table
// depends on vgsl_pkg and vgsl_ram
//
// channel   direction  handshake             payload
// req       in         req_valid/req_stall   vgsl_pkg::req_t
// rsp       out        rsp_valid/rsp_stall   vgsl_pkg::rsp_t
// cfg       in         cfg_valid/cfg_ready   table_enable bit
//
// table writes can follow back to back
// a lookup reads one table word per cycle through the single ram read port, then loads
// the output register in S_DONE: req_stall stays high until S_DONE has loaded the response,
// and S_DONE waits while the output register holds an unaccepted response,
// so a new lookup is not accepted before the last one is done; a range entry costs three reads
// no clearing pass after reset
module vertical_glyph_substitution_lookup #(
    parameter int TABLE_WORDS = vgsl_pkg::TABLE_WORDS_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            req_valid,
    output logic            req_stall,
    input  vgsl_pkg::req_t  req_data,
    output logic            rsp_valid,
    input  logic            rsp_stall,
    output vgsl_pkg::rsp_t  rsp_data,
    input  logic            cfg_valid,
    output logic            cfg_ready,
    input  logic            cfg_data
);

    localparam int AW = $clog2(TABLE_WORDS);
    localparam int PW = vgsl_pkg::PTR_W;
    localparam logic [PW-1:0] LIMIT = PW'(TABLE_WORDS);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_CTYPE = 4'd1;
    localparam logic [3:0] S_CNT   = 4'd2;
    localparam logic [3:0] S_COV1  = 4'd3;
    localparam logic [3:0] S_RA    = 4'd4;
    localparam logic [3:0] S_RB    = 4'd5;
    localparam logic [3:0] S_RC    = 4'd6;
    localparam logic [3:0] S_STYPE = 4'd7;
    localparam logic [3:0] S_SKIP  = 4'd8;
    localparam logic [3:0] S_HITW  = 4'd9;
    localparam logic [3:0] S_ENTRY = 4'd10;
    localparam logic [3:0] S_DONE  = 4'd11;

    logic [3:0]     state_reg, state_next;
    logic           enable_reg;
    logic           rsp_valid_reg, rsp_valid_next;
    vgsl_pkg::rsp_t rsp_reg, rsp_next;
    vgsl_pkg::rsp_t res_reg, res_next;
    logic [PW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [PW-1:0]  base_reg, base_next;
    logic [15:0]    cnt_reg, cnt_next;
    logic [15:0]    idx_reg, idx_next;
    logic           range_reg, range_next;
    logic [16:0]    hit_reg, hit_next;
    logic           hit_valid_reg, hit_valid_next;
    logic           delta_reg, delta_next;
    logic [15:0]    a_reg, a_next;
    logic [15:0]    b_reg, b_next;
    logic [15:0]    glyph_reg, glyph_next;

    logic           issue_en;
    logic [PW-1:0]  issue_addr;
    logic [3:0]     issue_state;
    logic [PW-1:0]  cov_end;
    logic [PW-1:0]  waddr_ext;
    logic           ram_we;
    logic [15:0]    rdata;
    logic           accept;

    assign accept    = req_valid && !req_stall;
    assign req_stall = (state_reg != S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp_data  = rsp_reg;
    assign cfg_ready = 1'b1;

    assign waddr_ext = PW'(req_data.word_address);
    assign ram_we    = accept && (req_data.kind == vgsl_pkg::KIND_WRITE) && (waddr_ext < LIMIT);
    assign cov_end   = range_reg ? (base_reg + (PW'(cnt_reg) << 1) + PW'(cnt_reg))
                                 : (base_reg + PW'(cnt_reg));

    vgsl_ram #(
        .WIDTH(16),
        .DEPTH(TABLE_WORDS)
    ) u_store (
        .clk  (clk),
        .we   (ram_we),
        .waddr(waddr_ext[AW-1:0]),
        .wdata(req_data.word_data),
        .raddr(issue_addr[AW-1:0]),
        .rdata(rdata)
    );

    always_comb
    begin
        state_next     = state_reg;
        rsp_valid_next = rsp_valid_reg;
        rsp_next       = rsp_reg;
        res_next       = res_reg;
        rd_ptr_next    = rd_ptr_reg;
        base_next      = base_reg;
        cnt_next       = cnt_reg;
        idx_next       = idx_reg;
        range_next     = range_reg;
        hit_next       = hit_reg;
        hit_valid_next = hit_valid_reg;
        delta_next     = delta_reg;
        a_next         = a_reg;
        b_next         = b_reg;
        glyph_next     = glyph_reg;
        issue_en       = 1'b0;
        issue_addr     = rd_ptr_reg + PW'(1);
        issue_state    = state_reg;

        if (rsp_valid_reg && !rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (accept && (req_data.kind == vgsl_pkg::KIND_LOOKUP))
                begin
                    glyph_next    = req_data.glyph;
                    hit_valid_next = 1'b0;
                    res_next      = '{result_glyph: req_data.glyph, substituted: 1'b0,
                                      table_error: 1'b0};
                    if (enable_reg)
                    begin
                        issue_en    = 1'b1;
                        issue_addr  = '0;
                        issue_state = S_CTYPE;
                    end
                    else
                    begin
                        state_next = S_DONE;
                    end
                end
            end
            S_CTYPE:
            begin
                if (rdata == vgsl_pkg::END_MARK)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    range_next  = (rdata == vgsl_pkg::COV_RANGE);
                    delta_next  = (rdata == vgsl_pkg::COV_LIST);
                    issue_en    = 1'b1;
                    issue_state = S_CNT;
                end
            end
            S_CNT:
            begin
                cnt_next   = rdata;
                idx_next   = '0;
                base_next  = rd_ptr_reg + PW'(1);
                issue_en   = 1'b1;
                // delta_reg briefly marks a glyph-list coverage here
                if (rdata == 16'd0 || (!range_reg && !delta_reg))
                begin
                    issue_state = S_STYPE;
                end
                else if (range_reg)
                begin
                    issue_state = S_RA;
                end
                else
                begin
                    issue_state = S_COV1;
                end
            end
            S_COV1:
            begin
                issue_en = 1'b1;
                if (rdata == glyph_reg)
                begin
                    hit_valid_next = 1'b1;
                    hit_next       = {1'b0, idx_reg};
                    issue_addr     = cov_end;
                    issue_state    = S_STYPE;
                end
                else
                begin
                    idx_next    = idx_reg + 16'd1;
                    issue_state = (idx_reg + 16'd1 == cnt_reg) ? S_STYPE : S_COV1;
                end
            end
            S_RA:
            begin
                a_next      = rdata;
                issue_en    = 1'b1;
                issue_state = S_RB;
            end
            S_RB:
            begin
                b_next      = rdata;
                issue_en    = 1'b1;
                issue_state = S_RC;
            end
            S_RC:
            begin
                issue_en = 1'b1;
                if (a_reg <= glyph_reg && glyph_reg <= b_reg)
                begin
                    hit_valid_next = 1'b1;
                    hit_next       = {1'b0, glyph_reg - a_reg} + {1'b0, rdata};
                    issue_addr     = cov_end;
                    issue_state    = S_STYPE;
                end
                else
                begin
                    idx_next    = idx_reg + 16'd1;
                    issue_state = (idx_reg + 16'd1 == cnt_reg) ? S_STYPE : S_RA;
                end
            end
            S_STYPE:
            begin
                delta_next = (rdata == vgsl_pkg::SUB_DELTA);
                issue_en   = 1'b1;
                if (hit_valid_reg)
                begin
                    issue_state = S_HITW;
                end
                else if (rdata == vgsl_pkg::SUB_DELTA)
                begin
                    issue_addr  = rd_ptr_reg + PW'(2);
                    issue_state = S_CTYPE;
                end
                else
                begin
                    issue_state = S_SKIP;
                end
            end
            S_SKIP:
            begin
                issue_en    = 1'b1;
                issue_addr  = rd_ptr_reg + PW'(1) + PW'(rdata);
                issue_state = S_CTYPE;
            end
            S_HITW:
            begin
                if (delta_reg)
                begin
                    res_next   = '{result_glyph: glyph_reg + rdata, substituted: 1'b1,
                                   table_error: 1'b0};
                    state_next = S_DONE;
                end
                else if (hit_reg < {1'b0, rdata})
                begin
                    issue_en    = 1'b1;
                    issue_addr  = rd_ptr_reg + PW'(1) + PW'(hit_reg);
                    issue_state = S_ENTRY;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_ENTRY:
            begin
                res_next   = '{result_glyph: rdata, substituted: 1'b1, table_error: 1'b0};
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    rsp_valid_next = 1'b1;
                    rsp_next       = res_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (issue_en)
        begin
            rd_ptr_next = issue_addr;
            if (issue_addr >= LIMIT)
            begin
                res_next   = '{result_glyph: glyph_reg, substituted: 1'b0, table_error: 1'b1};
                state_next = S_DONE;
                if (state_reg == S_IDLE)
                begin
                    res_next.result_glyph = req_data.glyph;
                end
            end
            else
            begin
                state_next = issue_state;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            enable_reg    <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                enable_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_reg       <= rsp_next;
        res_reg       <= res_next;
        rd_ptr_reg    <= rd_ptr_next;
        base_reg      <= base_next;
        cnt_reg       <= cnt_next;
        idx_reg       <= idx_next;
        range_reg     <= range_next;
        hit_reg       <= hit_next;
        hit_valid_reg <= hit_valid_next;
        delta_reg     <= delta_next;
        a_reg         <= a_next;
        b_reg         <= b_next;
        glyph_reg     <= glyph_next;
    end

endmodule

// ===== test/vgsl_checker.sv =====
// vgsl_checker: watches the request, response and config channels of the lookup block
// keeps its own copy of the table store and enable bit, predicts every lookup and
// compares each response field by field; depends on vgsl_pkg
module vgsl_checker #(
    parameter int TABLE_WORDS = vgsl_pkg::TABLE_WORDS_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            req_valid,
    input  logic            req_stall,
    input  vgsl_pkg::req_t  req_data,
    input  logic            rsp_valid,
    input  logic            rsp_stall,
    input  vgsl_pkg::rsp_t  rsp_data,
    input  logic            cfg_valid,
    input  logic            cfg_ready,
    input  logic            cfg_data,
    output int              errors,
    output int              pending
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [15:0]    table_copy [TABLE_WORDS];
    logic           enable_q;
    vgsl_pkg::rsp_t expected_glyphs [$];
    int             mismatches;

    task automatic report_mismatch(input string what, input logic [15:0] got,
                                   input logic [15:0] want);
        $display("mismatch at %0t ns: %s got %h expected %h", $time, what, got, want);
        mismatches++;
    endtask

    // negative return means the address lies past the store
    function automatic longint word_at(input longint addr);
        if (addr >= TABLE_WORDS)
            return -1;
        return longint'(table_copy[addr]);
    endfunction

    function automatic vgsl_pkg::rsp_t predict_vertical_glyph(input logic [15:0] glyph);
        vgsl_pkg::rsp_t keep;
        vgsl_pkg::rsp_t off_store;
        longint g;
        longint p;
        longint ctype;
        longint cnt;
        longint stype;
        longint w;
        longint a;
        longint b;
        longint c;
        longint hit;
        keep.result_glyph = glyph;
        keep.substituted  = 1'b0;
        keep.table_error  = 1'b0;
        off_store = keep;
        off_store.table_error = 1'b1;
        if (!enable_q)
            return keep;
        g = glyph;
        p = 0;
        while (1)
        begin
            ctype = word_at(p);
            if (ctype < 0)
                return off_store;
            if (ctype == vgsl_pkg::END_MARK)
                return keep;
            cnt = word_at(p + 1);
            if (cnt < 0)
                return off_store;
            p = p + 2;
            hit = -1;
            if (ctype == vgsl_pkg::COV_LIST)
            begin
                for (longint i = 0; i < cnt; i++)
                begin
                    w = word_at(p + i);
                    if (w < 0)
                        return off_store;
                    if (w == g)
                    begin
                        hit = i;
                        break;
                    end
                end
                p = p + cnt;
            end
            else if (ctype == vgsl_pkg::COV_RANGE)
            begin
                for (longint i = 0; i < cnt; i++)
                begin
                    a = word_at(p + 3 * i);
                    b = word_at(p + 3 * i + 1);
                    c = word_at(p + 3 * i + 2);
                    if (a < 0 || b < 0 || c < 0)
                        return off_store;
                    if (a <= g && g <= b)
                    begin
                        hit = g - a + c;
                        break;
                    end
                end
                p = p + 3 * cnt;
            end
            stype = word_at(p);
            if (stype < 0)
                return off_store;
            p = p + 1;
            if (hit >= 0)
            begin
                w = word_at(p);
                if (w < 0)
                    return off_store;
                if (stype == vgsl_pkg::SUB_DELTA)
                begin
                    w = (g + w) % 65536;
                    keep.result_glyph = w[15:0];
                    keep.substituted  = 1'b1;
                    return keep;
                end
                // index past the array leaves the glyph alone
                if (hit < w)
                begin
                    w = word_at(p + 1 + hit);
                    if (w < 0)
                        return off_store;
                    keep.result_glyph = w[15:0];
                    keep.substituted  = 1'b1;
                end
                return keep;
            end
            if (stype == vgsl_pkg::SUB_DELTA)
                p = p + 1;
            else
            begin
                cnt = word_at(p);
                if (cnt < 0)
                    return off_store;
                p = p + 1 + cnt;
            end
        end
        return keep;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        vgsl_pkg::rsp_t want;
        if (!rst_n)
        begin
            enable_q = 1'b0;
            expected_glyphs.delete();
            mismatches = 0;
            pending <= 0;
            errors  <= 0;
        end
        else
        begin
            if (rsp_valid && !rsp_stall)
            begin
                if (expected_glyphs.size() == 0)
                    report_mismatch("response with no lookup pending, result_glyph",
                                    rsp_data.result_glyph, 16'h0000);
                else
                begin
                    want = expected_glyphs.pop_front();
                    if (rsp_data.result_glyph !== want.result_glyph)
                        report_mismatch("result_glyph", rsp_data.result_glyph,
                                        want.result_glyph);
                    if (rsp_data.substituted !== want.substituted)
                        report_mismatch("substituted", {15'd0, rsp_data.substituted},
                                        {15'd0, want.substituted});
                    if (rsp_data.table_error !== want.table_error)
                        report_mismatch("table_error", {15'd0, rsp_data.table_error},
                                        {15'd0, want.table_error});
                end
            end
            if (cfg_valid && cfg_ready)
                enable_q = cfg_data;
            if (req_valid && !req_stall)
            begin
                if (req_data.kind == vgsl_pkg::KIND_WRITE)
                begin
                    if (req_data.word_address < TABLE_WORDS)
                        table_copy[req_data.word_address] = req_data.word_data;
                end
                else
                    expected_glyphs.push_back(predict_vertical_glyph(req_data.glyph));
            end
            pending <= expected_glyphs.size();
            errors  <= mismatches;
        end
    end

endmodule

// ===== test/vertical_glyph_substitution_lookup_test.sv =====
// vertical_glyph_substitution_lookup_test: stimulus and verdict for the glyph lookup block
// loads directed and random substitution tables, toggles table enable, sends lookups with
// random gaps and response stalls; depends on vgsl_pkg, vgsl_checker and the block itself
module vertical_glyph_substitution_lookup_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int          TABLE_WORDS = vgsl_pkg::TABLE_WORDS_DEF;
    localparam int          ITEM_TARGET = 1050;
    localparam int          SETTLE      = 8;
    localparam logic [15:0] SUB_ARRAY   = 16'd0;
    localparam logic [15:0] COV_UNKNOWN = 16'd7;

    typedef enum logic [1:0] {STALL_NONE, STALL_RANDOM, STALL_RUNS} stall_mode_t;

    logic           clk;
    logic           rst_n     = 1'b0;
    logic           req_valid = 1'b0;
    logic           req_stall;
    vgsl_pkg::req_t req_data  = '0;
    logic           rsp_valid;
    logic           rsp_stall = 1'b0;
    vgsl_pkg::rsp_t rsp_data;
    logic           cfg_valid = 1'b0;
    logic           cfg_ready;
    logic           cfg_data  = 1'b0;
    int             errors;
    int             pending;

    stall_mode_t stall_mode  = STALL_NONE;
    int          stall_run   = 0;
    logic        stall_level = 1'b0;
    bit          idle_on     = 1'b0;
    int          burst_left  = 0;

    logic [15:0] tbl [$];
    logic [15:0] probes [$];
    bit          tail_needed;
    int          writes_sent  = 0;
    int          lookups_sent = 0;
    int          table_loads  = 0;

    vertical_glyph_substitution_lookup #(
        .TABLE_WORDS (TABLE_WORDS)
    ) u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req_data  (req_data),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_data  (rsp_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    vgsl_checker #(
        .TABLE_WORDS (TABLE_WORDS)
    ) u_checker (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req_data  (req_data),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_data  (rsp_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .errors    (errors),
        .pending   (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #(5_000_000);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    always @(posedge clk)
    begin
        case (stall_mode)
            STALL_NONE:   rsp_stall <= 1'b0;
            STALL_RANDOM: rsp_stall <= ($urandom_range(0, 99) < 40);
            default:
            begin
                if (stall_run == 0)
                begin
                    stall_run   = $urandom_range(1, 24);
                    stall_level = !stall_level;
                end
                stall_run--;
                rsp_stall <= stall_level;
            end
        endcase
    end

    // bursts of back to back requests with random gaps in between
    task automatic send_req(input vgsl_pkg::req_t item);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap = idle_on ? $urandom_range(0, 6) : 0;
            if (gap > 0)
            begin
                req_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        req_valid <= 1'b1;
        req_data  <= item;
        do @(posedge clk); while (req_stall);
    endtask

    task automatic send_write(input int addr, input logic [15:0] data);
        vgsl_pkg::req_t item;
        item.kind         = vgsl_pkg::KIND_WRITE;
        item.word_address = addr[11:0];
        item.word_data    = data;
        item.glyph        = 16'($urandom);
        send_req(item);
        writes_sent++;
    endtask

    task automatic send_lookup(input logic [15:0] glyph);
        vgsl_pkg::req_t item;
        item.kind         = vgsl_pkg::KIND_LOOKUP;
        item.word_address = 12'($urandom);
        item.word_data    = 16'($urandom);
        item.glyph        = glyph;
        send_req(item);
        lookups_sent++;
    endtask

    task automatic wait_idle();
        req_valid <= 1'b0;
        burst_left = 0;
        do @(posedge clk); while (pending != 0);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_enable(input logic value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    // random well formed table; every word a lookup can read gets written
    task automatic build_table();
        int          n_sub;
        int          cnt;
        int          start;
        int          stop;
        int          base;
        int          jump;
        int          pick;
        logic [15:0] w;
        tbl.delete();
        probes.delete();
        tail_needed = 1'b0;
        n_sub = $urandom_range(1, 4);
        repeat (n_sub)
        begin
            pick = $urandom_range(0, 9);
            if (pick < 4)
            begin
                cnt = $urandom_range(0, 6);
                tbl.push_back(vgsl_pkg::COV_LIST);
                tbl.push_back(16'(cnt));
                repeat (cnt)
                begin
                    w = 16'($urandom);
                    tbl.push_back(w);
                    probes.push_back(w);
                end
            end
            else if (pick < 8)
            begin
                cnt = $urandom_range(0, 3);
                tbl.push_back(vgsl_pkg::COV_RANGE);
                tbl.push_back(16'(cnt));
                repeat (cnt)
                begin
                    start = $urandom_range(0, 65535);
                    stop  = start + $urandom_range(0, 12);
                    if (stop > 65535)
                        stop = 65535;
                    if ($urandom_range(0, 9) == 0)
                        stop = start - 1;
                    tbl.push_back(16'(start));
                    tbl.push_back(16'(stop));
                    tbl.push_back(16'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535)
                                                                   : $urandom_range(0, 6)));
                    probes.push_back(16'(start));
                    probes.push_back(16'(stop));
                    probes.push_back(16'(start - 1));
                    probes.push_back(16'(stop + 1));
                    probes.push_back(16'(start + (stop - start) / 2));
                end
            end
            else
            begin
                // unknown coverage type: count is read but holds no entries
                w = 16'($urandom_range(3, 65535));
                if (w == vgsl_pkg::END_MARK)
                    w = 16'd0;
                tbl.push_back(w);
                tbl.push_back(16'($urandom));
            end
            if ($urandom_range(0, 1) == 1)
            begin
                tbl.push_back(vgsl_pkg::SUB_DELTA);
                case ($urandom_range(0, 3))
                    0:       tbl.push_back(16'h0000);
                    1:       tbl.push_back(16'hFFFF);
                    default: tbl.push_back(16'($urandom));
                endcase
            end
            else
            begin
                w = ($urandom_range(0, 1) == 1) ? SUB_ARRAY : 16'($urandom);
                if (w == vgsl_pkg::SUB_DELTA)
                    w = 16'd2;
                cnt = $urandom_range(0, 8);
                tbl.push_back(w);
                tbl.push_back(16'(cnt));
                repeat (cnt) tbl.push_back(16'($urandom));
            end
        end
        if ($urandom_range(0, 6) != 0)
            tbl.push_back(vgsl_pkg::END_MARK);
        else
        begin
            // last subtable's array count jumps the walk to or past the store end
            base = tbl.size();
            pick = $urandom_range(0, 2);
            if (pick == 0)
                jump = TABLE_WORDS - 4 - base;
            else if (pick == 1)
            begin
                jump = TABLE_WORDS - 5 - base;
                tail_needed = 1'b1;
            end
            else
                jump = $urandom_range(TABLE_WORDS - 3 - base, 65535);
            tbl.push_back(vgsl_pkg::COV_LIST);
            tbl.push_back(16'd0);
            tbl.push_back(SUB_ARRAY);
            tbl.push_back(16'(jump));
        end
    endtask

    task automatic load_table();
        for (int i = 0; i < tbl.size(); i++)
            send_write(i, tbl[i]);
        if (tail_needed)
            send_write(TABLE_WORDS - 1, 16'($urandom));
        table_loads++;
    endtask

    initial
    begin : stimulus
        int          phase;
        int          n_items;
        int          pick;
        logic [15:0] g;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        idle_on    = 1'b1;
        stall_mode = STALL_RANDOM;

        // table disabled right after reset
        write_enable(1'b0);
        send_lookup(16'h0000);
        send_lookup(16'hFFFF);
        send_write(TABLE_WORDS - 1, 16'hFFFF);

        // list with zero delta, range with array and index past end, unknown type
        send_write(0, vgsl_pkg::COV_LIST);
        send_write(1, 16'd1);
        send_write(2, 16'hFFFF);
        send_write(3, vgsl_pkg::SUB_DELTA);
        send_write(4, 16'd0);
        send_write(5, vgsl_pkg::COV_RANGE);
        send_write(6, 16'd1);
        send_write(7, 16'd100);
        send_write(8, 16'd110);
        send_write(9, 16'd1);
        send_write(10, SUB_ARRAY);
        send_write(11, 16'd2);
        send_write(12, 16'hABCD);
        send_write(13, 16'h0000);
        send_write(14, COV_UNKNOWN);
        send_write(15, 16'hFFFF);
        send_write(16, vgsl_pkg::SUB_DELTA);
        send_write(17, 16'd5);
        send_write(18, vgsl_pkg::END_MARK);
        wait_idle();
        write_enable(1'b1);
        send_lookup(16'hFFFF);
        send_lookup(16'd99);
        send_lookup(16'd100);
        send_lookup(16'd101);
        send_lookup(16'd110);
        send_lookup(16'h0000);

        // walk runs off the store end
        send_write(0, vgsl_pkg::COV_LIST);
        send_write(1, 16'd0);
        send_write(2, SUB_ARRAY);
        send_write(3, 16'(TABLE_WORDS - 4));
        send_lookup(16'h1234);

        phase = 0;
        while (writes_sent + lookups_sent < ITEM_TARGET)
        begin
            idle_on    = (phase % 5 != 0) && ($urandom_range(0, 3) != 0);
            stall_mode = (phase % 5 == 0) ? STALL_NONE : stall_mode_t'($urandom_range(0, 2));
            wait_idle();
            write_enable($urandom_range(0, 4) != 0);
            build_table();
            load_table();
            n_items = $urandom_range(15, 35);
            repeat (n_items)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 15)
                    send_write($urandom_range(tbl.size(), TABLE_WORDS - 1), 16'($urandom));
                else
                begin
                    if (pick < 75 && probes.size() > 0)
                        g = probes[$urandom_range(0, probes.size() - 1)];
                    else if (pick < 82)
                        g = ($urandom_range(0, 1) == 1) ? 16'h0000 : 16'hFFFF;
                    else
                        g = 16'($urandom);
                    send_lookup(g);
                end
            end
            phase++;
        end

        wait_idle();
        $display("run covered %0d table loads, %0d word writes and %0d glyph lookups",
                 table_loads, writes_sent, lookups_sent);
        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
